FILE: rtl/core/uart_pkg.sv
// uart_pkg: transaction types and fixed constants for the 8n1 serial port
package uart_pkg;

    // one clock tick of input: optional byte to send and the sampled receive line
    typedef struct packed {
        logic       tx_load;
        logic [7:0] tx_data;
        logic       rx_line;
    } in_t;

    // one clock tick of result: line levels and receiver status
    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_valid;
        logic [7:0] rx_data;
    } out_t;

    localparam logic [15:0] BIT_PERIOD_RESET = 16'd868;
    localparam logic [7:0]  TX_SHIFT_IDLE    = 8'hFF;
    localparam logic [7:0]  RX_SHIFT_CLEAR   = 8'h00;
    localparam logic [15:0] TICK_ONE         = 16'd1;

endpackage

FILE: rtl/core/uart_8n1_tx_rx.sv
// a result is registered in the output register, or in the skid entry while that one is held by out_stall
// throughput: one input transaction per cycle while in_stall is low, set by the single-pass bit timing logic
// a two-entry output stage (output register plus skid) lets input go on while out stalls
// in_stall rises only when both output entries hold results
// reset (rst_n low, asynchronous): transmitter and receiver idle, bit_period = 868
// uart_8n1_tx_rx: top level of the serial transmitter and receiver
module uart_8n1_tx_rx
    import uart_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    localparam int IDX_W = $clog2(DATA_BITS + 3);
    localparam logic [IDX_W-1:0] IDX_IDLE  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_START = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DATA_BITS + 1);
    localparam logic [IDX_W-1:0] IDX_STOP  = IDX_W'(DATA_BITS + 2);
    localparam int               RX_BITS   = 8;

    logic [15:0]      bit_period_reg;
    logic [IDX_W-1:0] tx_idx_reg, tx_idx_next;
    logic [15:0]      tx_cnt_reg, tx_cnt_next;
    logic [7:0]       tx_shift_reg, tx_shift_next;
    logic [IDX_W-1:0] rx_idx_reg, rx_idx_next;
    logic [15:0]      rx_cnt_reg, rx_cnt_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;
    logic             out_valid_reg, skid_valid_reg;
    out_t             out_data_reg, skid_data_reg;

    logic             accept;
    logic             take;
    logic [15:0]      full_bit;
    logic [15:0]      half_bit;
    logic             tx_line_c;
    logic             tx_busy_c;
    logic             rx_valid_c;
    out_t             result;

    assign accept = in_valid && !in_stall;
    assign take   = out_valid_reg && !out_stall;

    // bit lengths, zero acts as one
    always_comb
    begin
        full_bit = (bit_period_reg == 16'd0) ? TICK_ONE : bit_period_reg;
        half_bit = (bit_period_reg[15:1] == 15'd0) ? TICK_ONE : {1'b0, bit_period_reg[15:1]};
    end

    // transmitter next state and line level
    always_comb
    begin
        logic [IDX_W-1:0] idx_a;
        logic [15:0]      cnt_a;
        logic [7:0]       shift_a;
        logic [15:0]      cnt_inc;
        idx_a   = tx_idx_reg;
        cnt_a   = tx_cnt_reg;
        shift_a = tx_shift_reg;
        if (tx_idx_reg == IDX_IDLE && in_data.tx_load)
        begin
            idx_a   = IDX_START;
            cnt_a   = 16'd0;
            shift_a = in_data.tx_data;
        end
        tx_idx_next   = idx_a;
        tx_cnt_next   = cnt_a;
        tx_shift_next = shift_a;
        tx_line_c     = 1'b1;
        tx_busy_c     = 1'b0;
        cnt_inc       = cnt_a + TICK_ONE;
        if (idx_a != IDX_IDLE)
        begin
            tx_busy_c = 1'b1;
            if (idx_a == IDX_START)
                tx_line_c = 1'b0;
            else if (idx_a <= IDX_LAST)
                tx_line_c = shift_a[0];
            tx_cnt_next = cnt_inc;
            if (cnt_inc >= full_bit || cnt_inc == 16'd0)
            begin
                tx_cnt_next = 16'd0;
                if (idx_a >= IDX_FIRST && idx_a <= IDX_LAST)
                    tx_shift_next = {1'b1, shift_a[7:1]};
                tx_idx_next = (idx_a == IDX_STOP) ? IDX_IDLE : idx_a + IDX_START;
            end
        end
    end

    // receiver next state
    always_comb
    begin
        logic [15:0]      target;
        logic [15:0]      cnt_inc;
        logic [IDX_W-1:0] pos;
        rx_idx_next   = rx_idx_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_shift_next = rx_shift_reg;
        rx_valid_c    = 1'b0;
        target        = (rx_idx_reg == IDX_START) ? half_bit : full_bit;
        cnt_inc       = rx_cnt_reg + TICK_ONE;
        pos           = rx_idx_reg - IDX_FIRST;
        if (rx_idx_reg == IDX_IDLE)
        begin
            if (!in_data.rx_line)
            begin
                rx_idx_next   = IDX_START;
                rx_cnt_next   = 16'd0;
                rx_shift_next = RX_SHIFT_CLEAR;
            end
        end
        else
        begin
            rx_cnt_next = cnt_inc;
            if (cnt_inc >= target || cnt_inc == 16'd0)
            begin
                rx_cnt_next = 16'd0;
                if (rx_idx_reg >= IDX_STOP)
                begin
                    rx_valid_c  = 1'b1;
                    rx_idx_next = IDX_IDLE;
                end
                else
                begin
                    if (rx_idx_reg >= IDX_FIRST && int'(pos) < RX_BITS && in_data.rx_line)
                        rx_shift_next[pos[2:0]] = 1'b1;
                    rx_idx_next = rx_idx_reg + IDX_START;
                end
            end
        end
    end

    // result of this tick
    assign result = {tx_line_c, tx_busy_c, rx_valid_c, rx_shift_next};

    // configuration and bit timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
            tx_idx_reg     <= IDX_IDLE;
            tx_cnt_reg     <= 16'd0;
            tx_shift_reg   <= TX_SHIFT_IDLE;
            rx_idx_reg     <= IDX_IDLE;
            rx_cnt_reg     <= 16'd0;
            rx_shift_reg   <= RX_SHIFT_CLEAR;
        end
        else
        begin
            if (cfg_write)
                bit_period_reg <= cfg_data;
            if (accept)
            begin
                tx_idx_reg   <= tx_idx_next;
                tx_cnt_reg   <= tx_cnt_next;
                tx_shift_reg <= tx_shift_next;
                rx_idx_reg   <= rx_idx_next;
                rx_cnt_reg   <= rx_cnt_next;
                rx_shift_reg <= rx_shift_next;
            end
        end
    end

    // output register and skid entry control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else if (!accept)
                out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid entry payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
                out_data_reg <= result;
            else
                skid_data_reg <= result;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/uart_8n1_tx_rx_checker.sv
// uart_8n1_tx_rx_checker: port-level assertions for the serial port, with its bind
module uart_8n1_tx_rx_checker
    import uart_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [15:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input in_t         in_data,
    input logic        out_valid,
    input logic        out_stall,
    input out_t        out_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    // input stalls only while the output side is full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // an accepted transaction always leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction produced no result");

    // idle transmitter keeps the line high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tx_busy |-> out_data.tx_line)
        else $error("tx line low while not busy");

    // reset empties both output entries
    assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("output not empty after reset");

endmodule

bind uart_8n1_tx_rx uart_8n1_tx_rx_checker u_checker (.*);

FILE: tb/uart_line_checker.sv
`timescale 1ns / 100ps
// uart_line_checker: watches both channels, predicts every tick of the serial port and compares
module uart_line_checker
    import uart_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_t         in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_t        out_data,
    output int          mismatches,
    output int          pending
);

    // predicted state of the port
    logic [15:0] period;
    logic [3:0]  tx_idx;
    logic [15:0] tx_cnt;
    logic [7:0]  tx_sr;
    logic [3:0]  rx_idx;
    logic [15:0] rx_cnt;
    logic [7:0]  rx_sr;

    // line levels and receiver status still owed by the block, oldest first
    out_t expected_ticks[$];

    // advance transmitter and receiver by one tick and return the levels seen
    function automatic out_t serial_tick(input in_t t);
        out_t        r;
        logic [15:0] full;
        logic [15:0] half;
        logic [15:0] target;
        int          pos;
        full = (period == 16'd0) ? TICK_ONE : period;
        half = ((period >> 1) == 16'd0) ? TICK_ONE : (period >> 1);
        r.tx_line  = 1'b1;
        r.tx_busy  = 1'b0;
        r.rx_valid = 1'b0;

        // transmitter: start bit shows on the load tick
        if (tx_idx == 4'd0 && t.tx_load)
        begin
            tx_idx = 4'd1;
            tx_cnt = '0;
            tx_sr  = t.tx_data;
        end
        if (tx_idx != 4'd0)
        begin
            r.tx_busy = 1'b1;
            if (tx_idx == 4'd1)
                r.tx_line = 1'b0;
            else if (tx_idx <= DATA_BITS + 1)
                r.tx_line = tx_sr[0];
            tx_cnt = tx_cnt + TICK_ONE;
            if (tx_cnt >= full || tx_cnt == 16'd0)
            begin
                tx_cnt = '0;
                if (tx_idx >= 4'd2 && tx_idx <= DATA_BITS + 1)
                    tx_sr = {1'b1, tx_sr[7:1]};
                tx_idx = tx_idx + 4'd1;
                if (tx_idx > DATA_BITS + 2)
                    tx_idx = 4'd0;
            end
        end

        // receiver: half-bit wait, data samples a full bit apart, unchecked stop
        if (rx_idx == 4'd0)
        begin
            if (!t.rx_line)
            begin
                rx_idx = 4'd1;
                rx_cnt = '0;
                rx_sr  = RX_SHIFT_CLEAR;
            end
        end
        else
        begin
            target = (rx_idx == 4'd1) ? half : full;
            rx_cnt = rx_cnt + TICK_ONE;
            if (rx_cnt >= target || rx_cnt == 16'd0)
            begin
                rx_cnt = '0;
                if (rx_idx >= DATA_BITS + 2)
                begin
                    r.rx_valid = 1'b1;
                    rx_idx     = 4'd0;
                end
                else
                begin
                    if (rx_idx >= 4'd2)
                    begin
                        pos = rx_idx - 2;
                        if (pos < 8 && t.rx_line)
                            rx_sr = rx_sr | (8'h01 << pos);
                    end
                    rx_idx = rx_idx + 4'd1;
                end
            end
        end

        r.rx_data = rx_sr;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // predict on accepted inputs, compare on accepted outputs
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            period     = BIT_PERIOD_RESET;
            tx_idx     = 4'd0;
            tx_cnt     = '0;
            tx_sr      = TX_SHIFT_IDLE;
            rx_idx     = 4'd0;
            rx_cnt     = '0;
            rx_sr      = RX_SHIFT_CLEAR;
            mismatches = 0;
            expected_ticks.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $error("output transaction with no expected result");
                    mismatches++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("tx_line", {7'd0, want.tx_line}, {7'd0, out_data.tx_line});
                    check_field("tx_busy", {7'd0, want.tx_busy}, {7'd0, out_data.tx_busy});
                    check_field("rx_valid", {7'd0, want.rx_valid},
                                {7'd0, out_data.rx_valid});
                    check_field("rx_data", want.rx_data, out_data.rx_data);
                end
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(serial_tick(in_data));
            if (cfg_write)
                period = cfg_data;
            pending <= expected_ticks.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for the 8n1 serial transmitter and receiver
module tb_top;
    import uart_pkg::*;

    localparam int DATA_BITS = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    int          mismatches;
    int          pending;

    bit quiet       = 1'b0;
    int baud        = int'(BIT_PERIOD_RESET);
    int phase_ticks = 0;
    int stall_left  = 0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    uart_8n1_tx_rx #(
        .DATA_BITS (DATA_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    uart_line_checker #(
        .DATA_BITS (DATA_BITS)
    ) line_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // random receiver back-pressure, off during quiet stretches
    always @(posedge clk)
    begin
        if (quiet)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if (coin(20))
            stall_left = pick_gap() + 1;
        out_stall <= (stall_left > 0);
    end

    // one serial tick as one input transaction
    task automatic send_tick(input bit load, input logic [7:0] data, input bit line);
        in_t item;
        int  gap;
        item.tx_load = load;
        item.tx_data = data;
        item.rx_line = line;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        phase_ticks++;
    endtask

    // idle line, start bit, data bits LSB first, stop bit; nbits below 10 cuts the frame
    task automatic send_frame(input logic [7:0] value, input int nbits, input int load_pct);
        int   p;
        int   b;
        logic lvl;
        p = (baud == 0) ? 1 : baud;
        repeat ($urandom_range(0, p))
            send_tick(coin(load_pct), 8'($urandom_range(0, 255)), 1'b1);
        for (b = 0; b < nbits; b++)
        begin
            if (b == 0)
                lvl = 1'b0;
            else if (b <= 8)
                lvl = value[b - 1];
            else
                lvl = 1'b1;
            repeat (p) send_tick(coin(load_pct), 8'($urandom_range(0, 255)), lvl);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // bit period only changes with nothing in flight
    task automatic set_period(input logic [15:0] value);
        wait_drain();
        @(posedge clk);
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        baud = int'(value);
    endtask

    // main stimulus
    initial
    begin
        int   phase;
        int   p;
        int   r;
        bit   held;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset period, then shortened while the start bit is under way
        send_tick(1'b1, 8'h5A, 1'b1);
        repeat (4) send_tick(1'b0, 8'h00, 1'b1);

        // zero period acts as one tick per bit; loads while busy are dropped
        set_period(16'd0);
        send_tick(1'b1, 8'h00, 1'b1);
        send_frame(8'h00, 10, 100);
        send_frame(8'hFF, 10, 0);

        // period one and an odd small period
        set_period(16'd1);
        send_tick(1'b1, 8'hFF, 1'b1);
        send_frame(8'hA5, 10, 0);
        set_period(16'd3);
        send_frame(8'h5A, 10, 30);
        set_period(16'd4);
        send_frame(8'h3C, 10, 10);

        // widest period: both sides start a frame, next write cuts the bit short
        set_period(16'hFFFF);
        send_tick(1'b1, 8'h81, 1'b0);
        repeat (20) send_tick(1'b0, 8'($urandom_range(0, 255)), 1'b1);

        // random phases: mostly clean frames, some cut frames, noise and idle
        held = 1'b0;
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                p = 4;
            else if (phase == 5)
                p = 16;
            else
                p = $urandom_range(4, 12);
            quiet = (phase == 1);
            set_period(p[15:0]);
            phase_ticks = 0;
            while (phase_ticks < 40)
            begin
                // hold the sender until the output side has caught up
                if (phase == 3 && phase_ticks >= 20 && !held)
                begin
                    wait_drain();
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                    held = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_frame(8'($urandom_range(0, 255)), 10, 5);
                else if (r < 85)
                    send_frame(8'($urandom_range(0, 255)), $urandom_range(1, 9), 5);
                else if (r < 95)
                    repeat ($urandom_range(1, 8))
                        send_tick(coin(5), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                else
                    repeat ($urandom_range(1, p))
                        send_tick(coin(20), 8'($urandom_range(0, 255)), 1'b1);
            end
        end
        quiet = 1'b0;

        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
